// ===== rtl/ltc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_pkg: shared types and constants of the leap-second timescale converter
// Codes, table entry layouts, sequencer states and leap unit control.
// ----------------------------------------------------------------------------
package ltc_pkg;

	localparam int TABLE_DEPTH_DEF    = 64;
	localparam int RATE_FRAC_BITS_DEF = 56;

	localparam logic [63:0] TT_SHIFT_NS = 64'd32184000000;

	typedef enum logic [1:0] {
		CMD_LOAD     = 2'd0,
		CMD_TO_TAI   = 2'd1,
		CMD_FROM_TAI = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		SCALE_TAI = 2'd0,
		SCALE_TT  = 2'd1,
		SCALE_UTC = 2'd2
	} scale_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EARLY = 2'd1,
		STAT_UNSUP = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FETCH,
		S_DIFF,
		S_MUL_LO,
		S_MUL_HI,
		S_ACC_HI,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [63:0] when_utc;
		logic [63:0] when_tai;
	} sw_entry_t;

	typedef struct packed {
		logic [39:0] offset_utc;
		logic [39:0] offset_tai;
		logic [63:0] ref_ns;
		logic [31:0] rate_utc;
		logic [31:0] rate_tai;
	} prm_entry_t;

	typedef struct packed {
		logic init;
		logic mul_lo;
		logic mul_hi;
		logic acc_hi;
	} leap_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/leap_second_timescale_converter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// leap_second_timescale_converter_core: TAI to and from TT or UTC
// Loads, TAI, TT and error beats pass from idle through the finish state to done;
// UTC beats add a search of the switch-time memory, one entry per cycle, then
// fetch and the multiply-accumulate states (diff, mul_lo, mul_hi, acc_hi).
// A new beat is not taken while busy; start is taken again in the done cycle.
// Reset clears entry_count and the sequencer; the table is undefined until
// loaded. The receiver cannot stall: done marks each result for a single cycle.
// ----------------------------------------------------------------------------
module leap_second_timescale_converter_core #(
	parameter int TABLE_DEPTH    = ltc_pkg::TABLE_DEPTH_DEF,
	parameter int RATE_FRAC_BITS = ltc_pkg::RATE_FRAC_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_wen,
	input  wire [6:0]         cfg_wdata,
	input  wire               start,
	output logic              busy,
	input  wire [1:0]         command,
	input  wire signed [63:0] time_ns,
	input  wire [1:0]         scale,
	input  wire [5:0]         entry_index,
	input  wire signed [63:0] entry_when_utc,
	input  wire signed [63:0] entry_when_tai,
	input  wire [39:0]        entry_offset_ns,
	input  wire [39:0]        entry_offset_tai_ns,
	input  wire signed [63:0] entry_ref_ns,
	input  wire [31:0]        entry_rate,
	input  wire [31:0]        entry_rate_tai,
	output logic              done,
	output logic signed [63:0] result_ns,
	output logic [1:0]        status
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if ((a[63] == b[63]) && (s[63] != a[63]))
			return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return s;
	endfunction

	function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a - b;
		if ((a[63] != b[63]) && (s[63] != a[63]))
			return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return s;
	endfunction

	ltc_pkg::state_t     state_q, state_next;
	logic [6:0]          cnt_q;
	logic                done_q;
	logic                valid_s1;
	logic [CNT_W-1:0]    idx_s1;
	logic [CNT_W-1:0]    issue_q;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    n_in;
	logic [CNT_W-1:0]    pick_q;
	logic [63:0]         t_q;
	logic [63:0]         op_q;
	logic                to_tai_q;
	logic                sub_q;
	logic                utc_q;
	logic                zero_q;
	ltc_pkg::stat_t      stat_q;
	logic [63:0]         result_q;
	logic [1:0]          status_q;

	logic                accept;
	logic                wr_en;
	ltc_pkg::sw_entry_t  wr_sw;
	ltc_pkg::prm_entry_t wr_prm;
	logic [IDX_W-1:0]    sw_addr;
	logic [IDX_W-1:0]    prm_addr;
	ltc_pkg::sw_entry_t  sw_rd;
	ltc_pkg::prm_entry_t prm_rd;
	logic [63:0]         sw_sel;
	logic                scan_hit;
	logic                scan_last;
	logic                scan_end;
	logic                scan_early;
	ltc_pkg::leap_ctl_t  leap_ctl;
	logic [63:0]         leap;
	logic [63:0]         fin_op;
	logic [63:0]         fin_sum;

	assign accept = start && !busy;
	assign n_in   = (32'(cnt_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cnt_q);

	assign wr_sw  = '{when_utc: entry_when_utc, when_tai: entry_when_tai};
	assign wr_prm = '{offset_utc: entry_offset_ns, offset_tai: entry_offset_tai_ns,
		ref_ns: entry_ref_ns, rate_utc: entry_rate, rate_tai: entry_rate_tai};

	ltc_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (IDX_W'(entry_index)),
		.wr_sw    (wr_sw),
		.wr_prm   (wr_prm),
		.sw_addr  (sw_addr),
		.sw_rd_q  (sw_rd),
		.prm_addr (prm_addr),
		.prm_rd_q (prm_rd)
	);

	ltc_leap #(
		.RATE_FRAC_BITS(RATE_FRAC_BITS)
	) u_leap (
		.clk    (clk),
		.ctl    (leap_ctl),
		.t      (t_q),
		.ref_ns (prm_rd.ref_ns),
		.offset (to_tai_q ? prm_rd.offset_utc : prm_rd.offset_tai),
		.rate   (to_tai_q ? prm_rd.rate_utc : prm_rd.rate_tai),
		.leap   (leap)
	);

	always_comb begin
		sw_sel     = to_tai_q ? sw_rd.when_utc : sw_rd.when_tai;
		scan_hit   = valid_s1 && ($signed(t_q) < $signed(sw_sel));
		scan_last  = valid_s1 && ((idx_s1 + CNT_W'(1)) == n_q);
		scan_end   = scan_hit || scan_last;
		scan_early = scan_hit && (idx_s1 == '0);
		fin_op     = utc_q ? leap : op_q;
		fin_sum    = sub_q ? sat_sub(t_q, fin_op) : sat_add(t_q, fin_op);
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ltc_pkg::S_IDLE: begin
				if (accept) begin
					if (ltc_pkg::cmd_t'(command) != ltc_pkg::CMD_LOAD
						&& ltc_pkg::cmd_t'(command) != ltc_pkg::CMD_TO_TAI
						&& ltc_pkg::cmd_t'(command) != ltc_pkg::CMD_FROM_TAI)
						state_next = ltc_pkg::S_FINISH;
					else if (ltc_pkg::cmd_t'(command) != ltc_pkg::CMD_LOAD
						&& ltc_pkg::scale_t'(scale) == ltc_pkg::SCALE_UTC
						&& n_in != '0)
						state_next = ltc_pkg::S_SCAN;
					else
						state_next = ltc_pkg::S_FINISH;
				end
			end
			ltc_pkg::S_SCAN: begin
				if (scan_end)
					state_next = scan_early ? ltc_pkg::S_FINISH : ltc_pkg::S_FETCH;
			end
			ltc_pkg::S_FETCH:  state_next = ltc_pkg::S_DIFF;
			ltc_pkg::S_DIFF:   state_next = ltc_pkg::S_MUL_LO;
			ltc_pkg::S_MUL_LO: state_next = ltc_pkg::S_MUL_HI;
			ltc_pkg::S_MUL_HI: state_next = ltc_pkg::S_ACC_HI;
			ltc_pkg::S_ACC_HI: state_next = ltc_pkg::S_FINISH;
			ltc_pkg::S_FINISH: state_next = ltc_pkg::S_IDLE;
			default:           state_next = ltc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy     = (state_q != ltc_pkg::S_IDLE);
		wr_en    = accept && (ltc_pkg::cmd_t'(command) == ltc_pkg::CMD_LOAD)
			&& (32'(entry_index) < TABLE_DEPTH);
		sw_addr  = issue_q[IDX_W-1:0];
		prm_addr = IDX_W'(pick_q - CNT_W'(1));
		leap_ctl = '{init: (state_q == ltc_pkg::S_DIFF),
			mul_lo: (state_q == ltc_pkg::S_MUL_LO),
			mul_hi: (state_q == ltc_pkg::S_MUL_HI),
			acc_hi: (state_q == ltc_pkg::S_ACC_HI)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ltc_pkg::S_IDLE;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			state_q <= state_next;
			done_q  <= (state_q == ltc_pkg::S_FINISH);
			if (cfg_wen)
				cnt_q <= cfg_wdata;
			if (state_q == ltc_pkg::S_SCAN)
				valid_s1 <= !scan_end && (issue_q < n_q);
			else
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_q;
		if (state_q == ltc_pkg::S_SCAN) begin
			issue_q <= issue_q + CNT_W'(1);
			if (scan_end)
				pick_q <= scan_hit ? idx_s1 : (idx_s1 + CNT_W'(1));
			if (scan_early) begin
				zero_q <= 1'b1;
				stat_q <= ltc_pkg::STAT_EARLY;
			end
		end
		if (accept) begin
			t_q      <= time_ns;
			n_q      <= n_in;
			issue_q  <= '0;
			to_tai_q <= (ltc_pkg::cmd_t'(command) == ltc_pkg::CMD_TO_TAI);
			op_q     <= '0;
			sub_q    <= 1'b0;
			utc_q    <= 1'b0;
			zero_q   <= 1'b0;
			stat_q   <= ltc_pkg::STAT_OK;
			unique case (ltc_pkg::cmd_t'(command))
				ltc_pkg::CMD_TO_TAI, ltc_pkg::CMD_FROM_TAI: begin
					unique case (ltc_pkg::scale_t'(scale))
						ltc_pkg::SCALE_TAI: ;
						ltc_pkg::SCALE_TT: begin
							op_q  <= ltc_pkg::TT_SHIFT_NS;
							sub_q <= (ltc_pkg::cmd_t'(command) == ltc_pkg::CMD_TO_TAI);
						end
						ltc_pkg::SCALE_UTC: begin
							utc_q <= 1'b1;
							sub_q <= (ltc_pkg::cmd_t'(command) == ltc_pkg::CMD_FROM_TAI);
							if (n_in == '0) begin
								zero_q <= 1'b1;
								stat_q <= ltc_pkg::STAT_EARLY;
							end
						end
						default: begin
							zero_q <= 1'b1;
							stat_q <= ltc_pkg::STAT_UNSUP;
						end
					endcase
				end
				default: zero_q <= 1'b1;
			endcase
		end
		if (state_q == ltc_pkg::S_FINISH) begin
			result_q <= zero_q ? '0 : fin_sum;
			status_q <= stat_q;
		end
	end

	assign done      = done_q;
	assign result_ns = result_q;
	assign status    = status_q;

endmodule
`default_nettype wire

// ===== rtl/ltc_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_table: leap table storage
// Switch-time memory for the search and parameter memory for the chosen
// entry, each with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ltc_table #(
	parameter int TABLE_DEPTH = ltc_pkg::TABLE_DEPTH_DEF,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [IDX_W-1:0]         wr_addr,
	input  ltc_pkg::sw_entry_t      wr_sw,
	input  ltc_pkg::prm_entry_t     wr_prm,
	input  wire [IDX_W-1:0]         sw_addr,
	output ltc_pkg::sw_entry_t      sw_rd_q,
	input  wire [IDX_W-1:0]         prm_addr,
	output ltc_pkg::prm_entry_t     prm_rd_q
);

	ltc_pkg::sw_entry_t  sw_mem  [TABLE_DEPTH];
	ltc_pkg::prm_entry_t prm_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sw_mem[wr_addr]  <= wr_sw;
			prm_mem[wr_addr] <= wr_prm;
		end
	end

	always_ff @(posedge clk) begin
		sw_rd_q  <= sw_mem[sw_addr];
		prm_rd_q <= prm_mem[prm_addr];
	end

endmodule
`default_nettype wire

// ===== rtl/ltc_leap.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_leap: leap amount unit
// floor(offset + (t - ref) * rate / 2^F + 1/2) by two 32x32 partial
// products accumulated into a fixed-point sum over successive cycles.
// ----------------------------------------------------------------------------
module ltc_leap #(
	parameter int RATE_FRAC_BITS = ltc_pkg::RATE_FRAC_BITS_DEF,
	localparam int ACC_W = RATE_FRAC_BITS + 64
) (
	input  wire                 clk,
	input  ltc_pkg::leap_ctl_t  ctl,
	input  wire [63:0]          t,
	input  wire [63:0]          ref_ns,
	input  wire [39:0]          offset,
	input  wire [31:0]          rate,
	output logic [63:0]         leap
);

	logic             neg_q;
	logic [63:0]      mag_q;
	logic [31:0]      rate_q;
	logic [63:0]      prod_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] term;
	logic [ACC_W-1:0] acc_next;

	always_comb begin
		term     = ctl.acc_hi ? (ACC_W'(prod_q) << 32) : ACC_W'(prod_q);
		acc_next = neg_q ? (acc_q - term) : (acc_q + term);
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			neg_q  <= $signed(t) < $signed(ref_ns);
			mag_q  <= ($signed(t) < $signed(ref_ns)) ? (ref_ns - t) : (t - ref_ns);
			rate_q <= rate;
			acc_q  <= (ACC_W'(offset) << RATE_FRAC_BITS) | (ACC_W'(1) << (RATE_FRAC_BITS - 1));
		end
		if (ctl.mul_lo) begin
			prod_q <= 64'(mag_q[31:0]) * 64'(rate_q);
		end
		if (ctl.mul_hi) begin
			acc_q  <= acc_next;
			prod_q <= 64'(mag_q[63:32]) * 64'(rate_q);
		end
		if (ctl.acc_hi) begin
			acc_q <= acc_next;
		end
	end

	assign leap = acc_q[RATE_FRAC_BITS +: 64];

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: leap-second timescale converter core
// Drives load and convert beats through the start/busy handshake and checks
// every result beat against an in-bench model of the leap table, TT shift and
// drift interpolation, or a fixed row's expected value. A short opening sequence
// covers the extremes and the error codes; randomised table phases follow.
// ----------------------------------------------------------------------------
module testbench;

	localparam int DEPTH = ltc_pkg::TABLE_DEPTH_DEF;
	localparam int FRAC = ltc_pkg::RATE_FRAC_BITS_DEF;
	localparam int ITEMS = 1700;
	localparam int QUIET_TAIL = 250;
	localparam logic [1:0] CMD_IGNORED = 2'd3;
	localparam logic [1:0] SCALE_BAD = 2'd3;
	localparam logic [63:0] T_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LEAP_37 = 64'd37_000_000_000;
	localparam logic [39:0] OFF_37 = 40'd37_000_000_000;
	localparam logic [39:0] OFF_MAX = 40'hFF_FFFF_FFFF;
	localparam logic [31:0] RATE_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic                 is_cfg;
		logic [6:0]           cfg_val;
		logic [1:0]           cmd;
		logic [63:0]          t;
		logic [1:0]           scale;
		logic [5:0]           idx;
		ltc_pkg::sw_entry_t   sw;
		ltc_pkg::prm_entry_t  prm;
		logic                 fixed;
		logic [63:0]          want_ns;
		ltc_pkg::stat_t       want_st;
	} step_t;

	typedef struct packed {
		logic [63:0]    ns;
		ltc_pkg::stat_t code;
	} conv_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [6:0] cfg_wdata;
	logic start;
	logic busy;
	logic done;
	logic signed [63:0] result_ns;
	logic [1:0] status;
	step_t cur;

	logic [6:0] tab_len;
	ltc_pkg::sw_entry_t tab_sw[DEPTH];
	ltc_pkg::prm_entry_t tab_prm[DEPTH];
	conv_t conversions_due[$];
	logic [DEPTH-1:0] slot_loaded;
	int beats_sent = 0;
	int errors = 0;
	step_t opening[$];

	leap_second_timescale_converter_core dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wen             (cfg_wen),
		.cfg_wdata           (cfg_wdata),
		.start               (start),
		.busy                (busy),
		.command             (cur.cmd),
		.time_ns             (cur.t),
		.scale               (cur.scale),
		.entry_index         (cur.idx),
		.entry_when_utc      (cur.sw.when_utc),
		.entry_when_tai      (cur.sw.when_tai),
		.entry_offset_ns     (cur.prm.offset_utc),
		.entry_offset_tai_ns (cur.prm.offset_tai),
		.entry_ref_ns        (cur.prm.ref_ns),
		.entry_rate          (cur.prm.rate_utc),
		.entry_rate_tai      (cur.prm.rate_tai),
		.done                (done),
		.result_ns           (result_ns),
		.status              (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic flag(input string what);
		errors++;
		if (errors <= 40)
			$display("ERROR at %0t ns: %s", $time, what);
	endtask

	task automatic add_opening(input step_t s);
		opening.insert(opening.size(), s);
	endtask

	function automatic logic [63:0] clamp_sum(logic [63:0] a, logic [63:0] b, logic subtract);
		logic [64:0] s;
		s = subtract ? {a[63], a} - {b[63], b} : {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? T_MIN : T_MAX;
		return s[63:0];
	endfunction

	// round half up of offset + (t - ref) * rate / 2^FRAC, exact in 128 bits
	function automatic logic [63:0] leap_ns(logic [39:0] off, logic [63:0] ref_at,
			logic [31:0] rate, logic [63:0] t);
		logic neg;
		logic [63:0] mag;
		logic [127:0] prod;
		logic [127:0] acc;
		neg = $signed(t) < $signed(ref_at);
		mag = neg ? ref_at - t : t - ref_at;
		prod = {64'd0, mag} * {96'd0, rate};
		acc = ({88'd0, off} << FRAC) + (128'd1 << (FRAC - 1));
		acc = neg ? acc - prod : acc + prod;
		return acc[FRAC +: 64];
	endfunction

	function automatic conv_t timescale_convert(step_t s);
		conv_t r;
		logic to_tai;
		int n;
		int i;
		r.ns = '0;
		r.code = ltc_pkg::STAT_OK;
		to_tai = (s.cmd == ltc_pkg::CMD_TO_TAI);
		n = (tab_len > DEPTH) ? DEPTH : int'(tab_len);
		case (s.cmd)
			ltc_pkg::CMD_LOAD: begin
				tab_sw[s.idx] = s.sw;
				tab_prm[s.idx] = s.prm;
			end
			ltc_pkg::CMD_TO_TAI, ltc_pkg::CMD_FROM_TAI: begin
				case (s.scale)
					ltc_pkg::SCALE_TAI: r.ns = s.t;
					ltc_pkg::SCALE_TT: r.ns = clamp_sum(s.t, ltc_pkg::TT_SHIFT_NS, to_tai);
					ltc_pkg::SCALE_UTC: begin
						i = 0;
						while (i < n && $signed(s.t) >= $signed(to_tai ?
								tab_sw[i].when_utc : tab_sw[i].when_tai))
							i++;
						if (i == 0)
							r.code = ltc_pkg::STAT_EARLY;
						else if (to_tai)
							r.ns = clamp_sum(s.t, leap_ns(tab_prm[i-1].offset_utc,
								tab_prm[i-1].ref_ns, tab_prm[i-1].rate_utc, s.t), 1'b0);
						else
							r.ns = clamp_sum(s.t, leap_ns(tab_prm[i-1].offset_tai,
								tab_prm[i-1].ref_ns, tab_prm[i-1].rate_tai, s.t), 1'b1);
					end
					default: r.code = ltc_pkg::STAT_UNSUP;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] rand_time();
		case ($urandom_range(0, 6))
			0: return T_MIN;
			1: return T_MAX;
			2: return 64'(int'($urandom_range(0, 4000)) - 2000);
			3: return 64'd1_600_000_000_000_000_000 + 64'($urandom) * 64'd1_000_000;
			4: return 64'd0 - 64'd1_600_000_000_000_000_000 - 64'($urandom) * 64'd997;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic step_t noise_step();
		step_t s;
		s.is_cfg = 1'b0;
		s.cfg_val = '0;
		s.cmd = 2'($urandom);
		s.t = {$urandom, $urandom};
		s.scale = 2'($urandom);
		s.idx = 6'($urandom);
		s.sw = {$urandom, $urandom, $urandom, $urandom};
		s.prm = 208'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		s.fixed = 1'b0;
		s.want_ns = '0;
		s.want_st = ltc_pkg::STAT_OK;
		return s;
	endfunction

	function automatic step_t conv_row(logic [1:0] cmd, logic [1:0] scale, logic [63:0] t,
			logic fixed, logic [63:0] want_ns, ltc_pkg::stat_t want_st);
		step_t s;
		s = noise_step();
		s.cmd = cmd;
		s.scale = scale;
		s.t = t;
		s.fixed = fixed;
		s.want_ns = want_ns;
		s.want_st = want_st;
		return s;
	endfunction

	function automatic step_t load_row(logic [5:0] idx, ltc_pkg::sw_entry_t sw,
			ltc_pkg::prm_entry_t prm);
		step_t s;
		s = noise_step();
		s.cmd = ltc_pkg::CMD_LOAD;
		s.idx = idx;
		s.sw = sw;
		s.prm = prm;
		s.fixed = 1'b1;
		s.want_ns = '0;
		s.want_st = ltc_pkg::STAT_OK;
		return s;
	endfunction

	function automatic step_t cfg_row(logic [6:0] v);
		step_t s;
		s = noise_step();
		s.is_cfg = 1'b1;
		s.cfg_val = v;
		return s;
	endfunction

	function automatic step_t random_convert();
		step_t s;
		int k;
		int eff;
		logic [63:0] base;
		logic [63:0] delta;
		s = noise_step();
		k = $urandom_range(0, 19);
		s.cmd = (k == 0) ? CMD_IGNORED : (k < 10) ? ltc_pkg::CMD_TO_TAI : ltc_pkg::CMD_FROM_TAI;
		k = $urandom_range(0, 9);
		s.scale = (k < 6) ? ltc_pkg::SCALE_UTC : (k < 7) ? ltc_pkg::SCALE_TAI :
			(k < 9) ? ltc_pkg::SCALE_TT : SCALE_BAD;
		eff = (tab_len > DEPTH) ? DEPTH : int'(tab_len);
		s.t = rand_time();
		if (s.scale == ltc_pkg::SCALE_UTC && eff > 0 && $urandom_range(0, 4) != 0) begin
			k = $urandom_range(0, eff - 1);
			base = (s.cmd == ltc_pkg::CMD_TO_TAI) ? tab_sw[k].when_utc : tab_sw[k].when_tai;
			case ($urandom_range(0, 2))
				0: delta = 64'(int'($urandom_range(0, 4)) - 2);
				1: delta = {$urandom, $urandom} >> $urandom_range(1, 63);
				default: delta = '0;
			endcase
			if ($urandom_range(0, 1) == 0)
				delta = 64'd0 - delta;
			s.t = base + delta;
		end
		return s;
	endfunction

	task automatic run_step(step_t s);
		if (s.is_cfg) begin
			@(negedge clk);
			start = 1'b0;
			while (conversions_due.size() != 0)
				@(negedge clk);
			cfg_wen = 1'b1;
			cfg_wdata = s.cfg_val;
			@(negedge clk);
			cfg_wen = 1'b0;
		end else begin
			if (beats_sent < ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
				@(negedge clk);
				start = 1'b0;
				repeat ($urandom_range(0, 16))
					@(negedge clk);
			end
			@(negedge clk);
			cur = s;
			start = 1'b1;
			do
				@(posedge clk);
			while (busy);
			if (s.cmd == ltc_pkg::CMD_LOAD)
				slot_loaded[s.idx] = 1'b1;
			beats_sent++;
		end
	endtask

	task automatic table_phase(logic widest);
		logic [63:0] utc_at[DEPTH];
		logic [63:0] tmp;
		int n;
		int i;
		int j;
		int p;
		logic ordered;
		logic [6:0] count;
		ltc_pkg::sw_entry_t sw;
		ltc_pkg::prm_entry_t prm;
		n = (widest || $urandom_range(0, 7) == 0) ? DEPTH : $urandom_range(1, 6);
		ordered = $urandom_range(0, 4) != 0;
		for (i = 0; i < n; i++)
			utc_at[i] = rand_time();
		if (ordered) begin
			for (i = 1; i < n; i++) begin
				tmp = utc_at[i];
				j = i;
				while (j > 0 && $signed(utc_at[j-1]) > $signed(tmp)) begin
					utc_at[j] = utc_at[j-1];
					j--;
				end
				utc_at[j] = tmp;
			end
		end
		for (i = 0; i <= n; i++) begin
			if ($urandom_range(0, 3) == 0)
				run_step(random_convert());
			sw.when_utc = (i < n) ? utc_at[i] : rand_time();
			sw.when_tai = (ordered && i < n) ?
				utc_at[i] + 64'($urandom_range(0, 40)) * 64'd1_000_000_000 : rand_time();
			prm.offset_utc = ($urandom_range(0, 2) == 0) ? 40'({$urandom, $urandom}) :
				40'($urandom_range(0, 40)) * 40'd1_000_000_000;
			prm.offset_tai = ($urandom_range(0, 3) == 0) ? 40'({$urandom, $urandom}) :
				prm.offset_utc - 40'($urandom_range(0, 1000));
			prm.ref_ns = ($urandom_range(0, 1) == 0) ? sw.when_utc + 64'($urandom) : rand_time();
			case ($urandom_range(0, 4))
				0: prm.rate_utc = '0;
				1: prm.rate_utc = RATE_MAX;
				default: prm.rate_utc = $urandom;
			endcase
			prm.rate_tai = ($urandom_range(0, 2) == 0) ? $urandom :
				prm.rate_utc - 32'($urandom_range(0, 255));
			// the extra pass may add a stray load to any slot
			if (i < n)
				run_step(load_row(6'(i), sw, prm));
			else if ($urandom_range(0, 2) == 0)
				run_step(load_row(6'($urandom_range(0, DEPTH - 1)), sw, prm));
		end
		p = 0;
		while (p < DEPTH && slot_loaded[p])
			p++;
		if (widest)
			count = 7'd127;
		else begin
			case ($urandom_range(0, 7))
				0: count = '0;
				1: count = 7'($urandom_range(0, p));
				2: count = (p == DEPTH) ? 7'($urandom_range(DEPTH, 127)) : 7'(n);
				default: count = 7'(n);
			endcase
		end
		run_step(cfg_row(count));
		repeat ($urandom_range(12, 40))
			run_step(random_convert());
	endtask

	always @(posedge clk) begin : watch
		conv_t w;
		if (arst_n) begin
			if (done) begin
				if (conversions_due.size() == 0)
					flag($sformatf("result beat with nothing pending: %h/%0d", result_ns, status));
				else begin
					w = conversions_due.pop_front();
					if (result_ns !== w.ns)
						flag($sformatf("result_ns %h, want %h", result_ns, w.ns));
					if (status !== w.code)
						flag($sformatf("status %0d, want %0d", status, w.code));
				end
			end
			if (start && !busy) begin
				w = timescale_convert(cur);
				if (cur.fixed)
					w = conv_t'{cur.want_ns, cur.want_st};
				conversions_due.insert(conversions_due.size(), w);
			end
			if (cfg_wen)
				tab_len = cfg_wdata;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		tab_len = '0;
		slot_loaded = '0;
		cur = noise_step();

		add_opening(conv_row(ltc_pkg::CMD_TO_TAI, ltc_pkg::SCALE_UTC, 64'd0, 1'b1, '0,
			ltc_pkg::STAT_EARLY));
		add_opening(conv_row(ltc_pkg::CMD_FROM_TAI, ltc_pkg::SCALE_UTC, T_MAX, 1'b1, '0,
			ltc_pkg::STAT_EARLY));
		add_opening(conv_row(ltc_pkg::CMD_TO_TAI, SCALE_BAD, T_MAX, 1'b1, '0,
			ltc_pkg::STAT_UNSUP));
		add_opening(conv_row(ltc_pkg::CMD_FROM_TAI, SCALE_BAD, T_MIN, 1'b1, '0,
			ltc_pkg::STAT_UNSUP));
		add_opening(conv_row(CMD_IGNORED, ltc_pkg::SCALE_TAI, T_MAX, 1'b1, '0,
			ltc_pkg::STAT_OK));
		add_opening(conv_row(ltc_pkg::CMD_TO_TAI, ltc_pkg::SCALE_TAI, T_MIN, 1'b1, T_MIN,
			ltc_pkg::STAT_OK));
		add_opening(conv_row(ltc_pkg::CMD_FROM_TAI, ltc_pkg::SCALE_TAI, T_MAX, 1'b1, T_MAX,
			ltc_pkg::STAT_OK));
		add_opening(conv_row(ltc_pkg::CMD_TO_TAI, ltc_pkg::SCALE_TT, T_MIN, 1'b1, T_MIN,
			ltc_pkg::STAT_OK));
		add_opening(conv_row(ltc_pkg::CMD_FROM_TAI, ltc_pkg::SCALE_TT, T_MAX, 1'b1, T_MAX,
			ltc_pkg::STAT_OK));
		add_opening(conv_row(ltc_pkg::CMD_FROM_TAI, ltc_pkg::SCALE_TT, 64'd0, 1'b1,
			ltc_pkg::TT_SHIFT_NS, ltc_pkg::STAT_OK));
		add_opening(load_row(6'd0, ltc_pkg::sw_entry_t'{T_MIN, T_MIN},
			ltc_pkg::prm_entry_t'{40'd0, 40'd0, 64'd0, 32'd0, 32'd0}));
		add_opening(load_row(6'd1, ltc_pkg::sw_entry_t'{64'd0, LEAP_37},
			ltc_pkg::prm_entry_t'{OFF_37, OFF_37, 64'd0, RATE_MAX, RATE_MAX}));
		add_opening(load_row(6'd2, ltc_pkg::sw_entry_t'{T_MAX, T_MAX},
			ltc_pkg::prm_entry_t'{OFF_MAX, OFF_MAX, T_MIN, RATE_MAX, RATE_MAX}));
		add_opening(load_row(6'd63, ltc_pkg::sw_entry_t'{T_MAX, T_MIN},
			ltc_pkg::prm_entry_t'{OFF_MAX, 40'd0, T_MAX, 32'd0, RATE_MAX}));
		add_opening(cfg_row(7'd3));
		add_opening(conv_row(ltc_pkg::CMD_TO_TAI, ltc_pkg::SCALE_UTC, 64'hFFFF_FFFF_FFFF_FFFF,
			1'b0, '0, ltc_pkg::STAT_OK));
		add_opening(conv_row(ltc_pkg::CMD_TO_TAI, ltc_pkg::SCALE_UTC, 64'd0, 1'b0, '0,
			ltc_pkg::STAT_OK));
		add_opening(conv_row(ltc_pkg::CMD_TO_TAI, ltc_pkg::SCALE_UTC, T_MAX, 1'b0, '0,
			ltc_pkg::STAT_OK));
		add_opening(conv_row(ltc_pkg::CMD_TO_TAI, ltc_pkg::SCALE_UTC, T_MIN, 1'b0, '0,
			ltc_pkg::STAT_OK));
		add_opening(conv_row(ltc_pkg::CMD_FROM_TAI, ltc_pkg::SCALE_UTC, LEAP_37, 1'b0, '0,
			ltc_pkg::STAT_OK));
		add_opening(conv_row(ltc_pkg::CMD_FROM_TAI, ltc_pkg::SCALE_UTC, LEAP_37 - 64'd1, 1'b0,
			'0, ltc_pkg::STAT_OK));
		add_opening(conv_row(ltc_pkg::CMD_FROM_TAI, ltc_pkg::SCALE_UTC, T_MAX, 1'b0, '0,
			ltc_pkg::STAT_OK));
		add_opening(cfg_row(7'd0));
		add_opening(conv_row(ltc_pkg::CMD_TO_TAI, ltc_pkg::SCALE_UTC, T_MAX, 1'b1, '0,
			ltc_pkg::STAT_EARLY));

		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (opening[i])
			run_step(opening[i]);
		table_phase(1'b1);
		while (beats_sent < ITEMS)
			table_phase(1'b0);

		@(negedge clk);
		start = 1'b0;
		while (conversions_due.size() != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ltc_pkg.sv
rtl/ltc_table.sv
rtl/ltc_leap.sv
rtl/leap_second_timescale_converter_core.sv
tb/testbench.sv
